// ===== src/lcdsw_pkg.sv =====
// lcdsw_pkg: shared types, codes and lookup tables of the segment lcd serial writer
// no dependencies
`timescale 1ns / 1ps

package lcdsw_pkg;

    // request function codes
    typedef enum logic [1:0] {
        FUNC_CMD   = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_DIGIT = 2'd2,
        FUNC_DASH  = 2'd3
    } t_func;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD0,
        ST_WAIT0,
        ST_LOAD1,
        ST_WAIT1
    } t_state;

    // one captured request
    typedef struct packed {
        t_func       func;
        logic [7:0]  cmd_byte;
        logic [5:0]  address;
        logic [3:0]  nibble;
        logic [2:0]  position;
        logic        sign_on;
        logic [7:0]  digit_code;
    } t_req;

    // frame load control from sequencer to shifter
    typedef struct packed {
        logic load;
        logic item_last;
    } t_load_ctl;

    localparam logic [3:0] CMD_PREFIX   = 4'b1000;
    localparam logic [2:0] WRITE_PREFIX = 3'b101;
    localparam int         CMD_BITS     = 12;
    localparam logic [7:0] ASCII_LOWER_A = 8'd97;
    localparam logic [7:0] ASCII_OFFSET  = 8'd87;
    localparam logic [3:0] DASH_FIRST   = 4'h2;
    localparam logic [3:0] DASH_SECOND  = 4'h0;

    // seven-segment pattern of a hex digit
    function automatic logic [6:0] seg_code(input logic [3:0] digit);
        logic [6:0] r;
        unique case (digit)
            4'h0: r = 7'h7D;
            4'h1: r = 7'h60;
            4'h2: r = 7'h3E;
            4'h3: r = 7'h7A;
            4'h4: r = 7'h63;
            4'h5: r = 7'h5B;
            4'h6: r = 7'h5F;
            4'h7: r = 7'h70;
            4'h8: r = 7'h7F;
            4'h9: r = 7'h7B;
            4'hA: r = 7'h77;
            4'hB: r = 7'h4F;
            4'hC: r = 7'h1D;
            4'hD: r = 7'h6E;
            4'hE: r = 7'h1F;
            default: r = 7'h17;
        endcase
        return r;
    endfunction

    // segment address of the low nibble of a digit position
    function automatic logic [4:0] pos_first(input logic [2:0] pos);
        logic [4:0] r;
        unique case (pos)
            3'd1: r = 5'd10;
            3'd2: r = 5'd8;
            3'd3: r = 5'd6;
            3'd4: r = 5'd4;
            3'd5: r = 5'd2;
            3'd6: r = 5'd14;
            3'd7: r = 5'd16;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // segment address of the high nibble of a digit position
    function automatic logic [4:0] pos_second(input logic [2:0] pos);
        logic [4:0] r;
        unique case (pos)
            3'd1: r = 5'd9;
            3'd2: r = 5'd7;
            3'd3: r = 5'd5;
            3'd4: r = 5'd3;
            3'd5: r = 5'd1;
            3'd6: r = 5'd13;
            3'd7: r = 5'd15;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/lcdsw_if.sv =====
// lcdsw_req_if and lcdsw_bit_if: valid/ready channels of the segment lcd serial writer
// depends on lcdsw_pkg
`timescale 1ns / 1ps

interface lcdsw_req_if;
    import lcdsw_pkg::*;
    logic       valid;
    logic       ready;
    t_func      func;
    logic [7:0] cmd_byte;
    logic [5:0] address;
    logic [3:0] nibble;
    logic [2:0] position;
    logic       sign_on;
    logic [7:0] digit_code;

    modport source (
        output valid, func, cmd_byte, address, nibble, position, sign_on, digit_code,
        input  ready
    );
    modport sink (
        input  valid, func, cmd_byte, address, nibble, position, sign_on, digit_code,
        output ready
    );
endinterface

interface lcdsw_bit_if;
    logic valid;
    logic ready;
    logic data_bit;
    logic frame_end;
    logic item_end;

    modport source (
        output valid, data_bit, frame_end, item_end,
        input  ready
    );
    modport sink (
        input  valid, data_bit, frame_end, item_end,
        output ready
    );
endinterface

// ===== src/lcd_segment_serial_writer_unit.sv =====
// lcd_segment_serial_writer_unit: top level of the segment lcd serial writer
// depends on lcdsw_pkg, lcdsw_if, lcdsw_frame_build and lcdsw_shifter
`timescale 1ns / 1ps

// Turns one request into the serial frames of a segment lcd controller, one data
// bit per output request, msb first. A command request gives one 12-bit frame
// (1000 + command byte); a nibble write gives one frame of 101, ADDRESS_BITS
// address bits and four data bits; a digit or dash request gives two such write
// frames to the position's address pair. frame_end marks the last bit of every
// frame, item_end the last bit of the request. A bad position or digit code gives
// no output at all. One request is handled at a time: after capture, each frame
// is loaded into the shifter, shifted out bit by bit as the sink takes the bits,
// and waited on until the shifter drains before the next frame or request. The
// single bit shift register sets the pace.

module lcd_segment_serial_writer_unit
    import lcdsw_pkg::*;
#(
    parameter int ADDRESS_BITS = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lcdsw_req_if.sink     i_req,
    lcdsw_bit_if.source   o_bit
);

    // frame holds the longer of the command frame and the write frame
    localparam int FW = (ADDRESS_BITS + 7 > CMD_BITS) ? (ADDRESS_BITS + 7) : CMD_BITS;
    localparam int LW = $clog2(FW + 1);

    t_state        r_state, n_state;
    t_req          r_req;
    t_load_ctl     ctl;
    logic          frame_sel;
    logic [FW-1:0] word;
    logic [LW-1:0] len;
    logic          req_ok;
    logic          two_frames;
    logic          shifter_idle;
    logic          accept;

    assign accept = i_req.valid && i_req.ready;

    // capture the request; payload register needs no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.func       <= i_req.func;
            r_req.cmd_byte   <= i_req.cmd_byte;
            r_req.address    <= i_req.address;
            r_req.nibble     <= i_req.nibble;
            r_req.position   <= i_req.position;
            r_req.sign_on    <= i_req.sign_on;
            r_req.digit_code <= i_req.digit_code;
        end
    end

    // frame forming for the current frame slot
    lcdsw_frame_build #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .FW           (FW),
        .LW           (LW)
    ) u_build (
        .i_req       (r_req),
        .i_frame_sel (frame_sel),
        .o_word      (word),
        .o_len       (len),
        .o_ok        (req_ok),
        .o_two       (two_frames)
    );

    // bit shifter, its output register parts the sides
    lcdsw_shifter #(
        .FW (FW),
        .LW (LW)
    ) u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_word  (word),
        .i_len   (len),
        .o_idle  (shifter_idle),
        .o_bit   (o_bit)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept) n_state = ST_LOAD0;
            ST_LOAD0: n_state = req_ok ? ST_WAIT0 : ST_IDLE;
            ST_WAIT0: begin
                if (shifter_idle) n_state = two_frames ? ST_LOAD1 : ST_IDLE;
            end
            ST_LOAD1: n_state = ST_WAIT1;
            ST_WAIT1: if (shifter_idle) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_req.ready   = 1'b0;
        frame_sel     = 1'b0;
        ctl.load      = 1'b0;
        ctl.item_last = 1'b0;
        unique case (r_state)
            ST_IDLE:  i_req.ready = 1'b1;
            ST_LOAD0: begin
                // invalid requests are dropped without any frame
                ctl.load      = req_ok;
                ctl.item_last = !two_frames;
            end
            ST_LOAD1: begin
                frame_sel     = 1'b1;
                ctl.load      = 1'b1;
                ctl.item_last = 1'b1;
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/lcdsw_frame_build.sv =====
// lcdsw_frame_build: forms the left-aligned bit frame for one frame slot of a request
// depends on lcdsw_pkg
`timescale 1ns / 1ps

module lcdsw_frame_build
    import lcdsw_pkg::*;
#(
    parameter int ADDRESS_BITS = 6,
    parameter int FW = 13,
    parameter int LW = 4
) (
    input  t_req           i_req,
    input  logic           i_frame_sel,
    output logic [FW-1:0]  o_word,
    output logic [LW-1:0]  o_len,
    output logic           o_ok,
    output logic           o_two
);

    localparam int WW = ADDRESS_BITS + 7;

    logic [7:0]               adj_code;
    logic [7:0]               mapped;
    logic                     digit_ok;
    logic [7:0]               seg;
    logic [4:0]               pos_addr;
    logic [ADDRESS_BITS+5:0]  addr_in_ext;
    logic [ADDRESS_BITS+5:0]  addr_pos_ext;
    logic [ADDRESS_BITS-1:0]  addr_ab;
    logic [3:0]               data;
    logic [WW-1:0]            wr_word;
    logic [FW-1:0]            cmd_aligned;
    logic [FW-1:0]            wr_aligned;

    // ascii a..f folds onto 10..15, anything past 15 is rejected
    assign adj_code = i_req.digit_code - ASCII_OFFSET;
    assign mapped   = (i_req.digit_code >= ASCII_LOWER_A) ? adj_code : i_req.digit_code;
    assign digit_ok = (mapped[7:4] == 4'd0);
    assign seg      = {i_req.sign_on, seg_code(mapped[3:0])};

    assign pos_addr     = i_frame_sel ? pos_second(i_req.position) : pos_first(i_req.position);
    assign addr_in_ext  = {{ADDRESS_BITS{1'b0}}, i_req.address};
    assign addr_pos_ext = {{(ADDRESS_BITS + 1){1'b0}}, pos_addr};

    always_comb begin
        unique case (i_req.func)
            FUNC_WRITE: begin
                addr_ab = addr_in_ext[ADDRESS_BITS-1:0];
                data    = i_req.nibble;
            end
            FUNC_DIGIT: begin
                addr_ab = addr_pos_ext[ADDRESS_BITS-1:0];
                data    = i_frame_sel ? seg[7:4] : seg[3:0];
            end
            default: begin
                addr_ab = addr_pos_ext[ADDRESS_BITS-1:0];
                data    = i_frame_sel ? DASH_SECOND : DASH_FIRST;
            end
        endcase
    end

    assign wr_word     = {WRITE_PREFIX, addr_ab, data};
    assign wr_aligned  = FW'(wr_word) << (FW - WW);
    assign cmd_aligned = FW'({CMD_PREFIX, i_req.cmd_byte}) << (FW - CMD_BITS);

    always_comb begin
        if (i_req.func == FUNC_CMD) begin
            o_word = cmd_aligned;
            o_len  = LW'(CMD_BITS);
        end else begin
            o_word = wr_aligned;
            o_len  = LW'(WW);
        end
    end

    always_comb begin
        unique case (i_req.func)
            FUNC_CMD, FUNC_WRITE: o_ok = 1'b1;
            FUNC_DIGIT:           o_ok = (i_req.position != 3'd0) && digit_ok;
            default:              o_ok = (i_req.position != 3'd0);
        endcase
    end

    assign o_two = (i_req.func == FUNC_DIGIT) || (i_req.func == FUNC_DASH);

endmodule

// ===== src/lcdsw_shifter.sv =====
// lcdsw_shifter: msb-first shift register that puts one frame bit per request on the bit channel
// depends on lcdsw_pkg and lcdsw_bit_if
`timescale 1ns / 1ps

module lcdsw_shifter
    import lcdsw_pkg::*;
#(
    parameter int FW = 13,
    parameter int LW = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_load_ctl      i_ctl,
    input  logic [FW-1:0]  i_word,
    input  logic [LW-1:0]  i_len,
    output logic           o_idle,
    lcdsw_bit_if.source    o_bit
);

    logic [FW-1:0] r_shift, n_shift;
    logic [LW-1:0] r_cnt, n_cnt;
    logic          r_item_last, n_item_last;
    logic          take;

    assign o_idle          = (r_cnt == '0);
    assign o_bit.valid     = !o_idle;
    assign o_bit.data_bit  = r_shift[FW-1];
    assign o_bit.frame_end = (r_cnt == LW'(1));
    assign o_bit.item_end  = o_bit.frame_end && r_item_last;
    assign take            = o_bit.valid && o_bit.ready;

    always_comb begin
        n_shift     = r_shift;
        n_cnt       = r_cnt;
        n_item_last = r_item_last;
        if (i_ctl.load) begin
            n_shift     = i_word;
            n_cnt       = i_len;
            n_item_last = i_ctl.item_last;
        end else if (take) begin
            n_shift = r_shift << 1;
            n_cnt   = r_cnt - LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_shift     <= n_shift;
        r_item_last <= n_item_last;
    end

endmodule
